// ----- hw/rtl/rdqs_pkg.sv -----
// ----------------------------------------------------------------------------
// rdqs_pkg: shared types and constants of the record deque with search
// Sizes of the record ring, operation codes, the stored record layout and
// the ring index arithmetic.
// ----------------------------------------------------------------------------
`default_nettype none

package rdqs_pkg;

    // Number of record slots in the ring.
    localparam int CAPACITY = 64;
    // Slot index width and entry count width (count reaches CAPACITY itself).
    localparam int SLOT_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int COUNT_W  = $clog2(CAPACITY + 1);
    // Width used to compare an 8-bit position against the count.
    localparam int POS_CMP_W = (COUNT_W > 8) ? COUNT_W : 8;

    typedef logic [SLOT_W-1:0]  slot_t;
    typedef logic [COUNT_W-1:0] count_t;

    typedef enum logic [2:0] {
        OP_INS_FRONT   = 3'd0,
        OP_INS_BACK    = 3'd1,
        OP_REM_FRONT   = 3'd2,
        OP_REM_BACK    = 3'd3,
        OP_LOOKUP_POS  = 3'd4,
        OP_LOOKUP_CODE = 3'd5
    } op_t;

    typedef struct packed {
        logic signed [31:0] code;
        logic [31:0]        name_high;
        logic [63:0]        name_mid;
        logic [63:0]        name_low;
        logic [7:0]         age;
    } rec_t;

    // Ring index of base + off, both below CAPACITY.
    function automatic slot_t slot_add(input slot_t base, input slot_t off);
        logic [SLOT_W:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= (SLOT_W + 1)'(CAPACITY)) begin
            sum = sum - (SLOT_W + 1)'(CAPACITY);
        end
        return sum[SLOT_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/record_deque_with_search_unit.sv -----
// ----------------------------------------------------------------------------
// record_deque_with_search_unit: bounded record deque with lookup
// Ring of records with insert and remove at both ends, lookup by position
// and a sequential scan for the first record matching a code.
// ----------------------------------------------------------------------------
//
// Usage:
//   Input channel s_*: one word per operation (s_operation selects insert
//   front/back, remove front/back, lookup by 1-based position, lookup by
//   code). Output channel m_*: exactly one result word per operation, in
//   order: m_ok plus the found record (all zero unless a lookup hit).
//   The block works on one word at a time; s_ready is high only while the
//   sequencer is idle. Insert, remove and unused codes pass through the
//   execute state to the hand-over state; a lookup by position reads its
//   slot and captures the record first, or goes straight to hand-over when
//   the position is out of range; a lookup by code scans from the front
//   until a hit or the end of the list, and an empty list goes straight to
//   hand-over. The code scan reads one slot per cycle through the single
//   read port of the record memory and compares it in the following cycle,
//   so the scan length sets the worst case. The next word is taken in the
//   cycle after its result loads into the output register.
//   A finished result sits in the output register; a new word is taken
//   while it waits, and the sequencer holds in its hand-over state only
//   when it has a second result before m_ready takes the first.
//   Reset (aresetn low, synchronous) empties the list and drops any pending
//   result. Record memory is not cleared; only data from written slots is ever used.
// ----------------------------------------------------------------------------
`default_nettype none

module record_deque_with_search_unit (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    // operation words
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic [2:0]          s_operation,
    input  wire logic signed [31:0]  s_code,
    input  wire logic [63:0]         s_name_bytes_low,
    input  wire logic [63:0]         s_name_bytes_mid,
    input  wire logic [31:0]         s_name_bytes_high,
    input  wire logic [7:0]          s_age_in,
    input  wire logic [7:0]          s_position,
    // result words
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic                     m_ok,
    output logic signed [31:0]       m_found_code,
    output logic [63:0]              m_found_name_low,
    output logic [63:0]              m_found_name_mid,
    output logic [31:0]              m_found_name_high,
    output logic [7:0]               m_found_age
);

    // Sequencer states, one-hot.
    typedef enum logic [5:0] {
        ST_IDLE    = 6'b000001,
        ST_EXEC    = 6'b000010,
        ST_POS_RD  = 6'b000100,
        ST_POS_CAP = 6'b001000,
        ST_SCAN    = 6'b010000,
        ST_LOAD    = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // Ring bookkeeping.
    rdqs_pkg::count_t count_reg, count_next;
    rdqs_pkg::slot_t  front_reg, front_next;

    // Captured operation word.
    logic [2:0]       op_reg, op_next;
    rdqs_pkg::rec_t   in_rec_reg, in_rec_next;
    logic [7:0]       pos_reg, pos_next;

    // Scan control: offset to read next, and a valid flag on the read in flight.
    rdqs_pkg::count_t idx_reg, idx_next;
    logic             cmp_vld_reg, cmp_vld_next;

    // Pending result.
    logic             res_ok_reg, res_ok_next;
    rdqs_pkg::rec_t   res_rec_reg, res_rec_next;

    // Output register.
    logic             m_valid_reg, m_valid_next;
    logic             m_ok_reg, m_ok_next;
    rdqs_pkg::rec_t   m_rec_reg, m_rec_next;

    // Record memory: one write port, one registered read port.
    rdqs_pkg::rec_t   rec_mem [rdqs_pkg::CAPACITY];
    rdqs_pkg::rec_t   rd_data_reg;
    rdqs_pkg::slot_t  rd_addr;
    rdqs_pkg::slot_t  wr_addr;
    logic             wr_en;

    logic             accept;
    logic             pos_in_range;
    rdqs_pkg::slot_t  pos_slot;
    rdqs_pkg::slot_t  scan_slot;
    logic             scan_issue;
    logic             scan_hit;
    logic             out_free;

    assign accept   = s_valid && s_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign out_free = !m_valid_reg || m_ready;

    assign pos_in_range = (pos_reg != 8'd0) &&
        (rdqs_pkg::POS_CMP_W'(pos_reg) <= rdqs_pkg::POS_CMP_W'(count_reg));
    assign pos_slot  = rdqs_pkg::slot_add(front_reg,
                                          rdqs_pkg::SLOT_W'(pos_reg - 8'd1));
    assign scan_slot = rdqs_pkg::slot_add(front_reg, idx_reg[rdqs_pkg::SLOT_W-1:0]);
    assign scan_issue = (idx_reg < count_reg);
    assign scan_hit   = cmp_vld_reg && (rd_data_reg.code == in_rec_reg.code);

    // Read address: the position slot in its read state, the scan slot otherwise.
    assign rd_addr = (state_reg == ST_POS_RD) ? pos_slot : scan_slot;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            rec_mem[wr_addr] <= in_rec_reg;
        end
        rd_data_reg <= rec_mem[rd_addr];
    end

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        front_next   = front_reg;
        op_next      = op_reg;
        in_rec_next  = in_rec_reg;
        pos_next     = pos_reg;
        idx_next     = idx_reg;
        cmp_vld_next = cmp_vld_reg;
        res_ok_next  = res_ok_reg;
        res_rec_next = res_rec_reg;
        m_valid_next = m_valid_reg;
        m_ok_next    = m_ok_reg;
        m_rec_next   = m_rec_reg;
        wr_en        = 1'b0;
        wr_addr      = front_reg;

        // Drop the result word once the receiver takes it.
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    op_next               = s_operation;
                    in_rec_next.code      = s_code;
                    in_rec_next.name_low  = s_name_bytes_low;
                    in_rec_next.name_mid  = s_name_bytes_mid;
                    in_rec_next.name_high = s_name_bytes_high;
                    in_rec_next.age       = s_age_in;
                    pos_next              = s_position;
                    res_ok_next           = 1'b0;
                    res_rec_next          = '0;
                    idx_next              = '0;
                    cmp_vld_next          = 1'b0;
                    case (s_operation)
                        rdqs_pkg::OP_LOOKUP_POS:  state_next = ST_POS_RD;
                        rdqs_pkg::OP_LOOKUP_CODE: state_next = ST_SCAN;
                        default:                  state_next = ST_EXEC;
                    endcase
                end
            end

            ST_EXEC: begin
                state_next = ST_LOAD;
                case (op_reg)
                    rdqs_pkg::OP_INS_FRONT: begin
                        if (count_reg < rdqs_pkg::COUNT_W'(rdqs_pkg::CAPACITY)) begin
                            front_next  = rdqs_pkg::slot_add(front_reg,
                                rdqs_pkg::SLOT_W'(rdqs_pkg::CAPACITY - 1));
                            wr_en       = 1'b1;
                            wr_addr     = front_next;
                            count_next  = count_reg + rdqs_pkg::COUNT_W'(1);
                            res_ok_next = 1'b1;
                        end
                    end
                    rdqs_pkg::OP_INS_BACK: begin
                        if (count_reg < rdqs_pkg::COUNT_W'(rdqs_pkg::CAPACITY)) begin
                            wr_en       = 1'b1;
                            wr_addr     = rdqs_pkg::slot_add(front_reg,
                                count_reg[rdqs_pkg::SLOT_W-1:0]);
                            count_next  = count_reg + rdqs_pkg::COUNT_W'(1);
                            res_ok_next = 1'b1;
                        end
                    end
                    rdqs_pkg::OP_REM_FRONT: begin
                        if (count_reg != '0) begin
                            front_next  = rdqs_pkg::slot_add(front_reg,
                                rdqs_pkg::SLOT_W'(1));
                            count_next  = count_reg - rdqs_pkg::COUNT_W'(1);
                            res_ok_next = 1'b1;
                        end
                    end
                    rdqs_pkg::OP_REM_BACK: begin
                        if (count_reg != '0) begin
                            count_next  = count_reg - rdqs_pkg::COUNT_W'(1);
                            res_ok_next = 1'b1;
                        end
                    end
                    default: begin
                        // Unused codes answer with a failed result.
                    end
                endcase
            end

            ST_POS_RD: begin
                // Read the slot; out-of-range positions fail at once.
                state_next = pos_in_range ? ST_POS_CAP : ST_LOAD;
            end

            ST_POS_CAP: begin
                res_ok_next  = 1'b1;
                res_rec_next = rd_data_reg;
                state_next   = ST_LOAD;
            end

            ST_SCAN: begin
                // Issue one read per cycle, compare the previous read.
                if (scan_issue) begin
                    idx_next = idx_reg + rdqs_pkg::COUNT_W'(1);
                end
                cmp_vld_next = scan_issue;
                if (scan_hit) begin
                    res_ok_next  = 1'b1;
                    res_rec_next = rd_data_reg;
                    cmp_vld_next = 1'b0;
                    state_next   = ST_LOAD;
                end else if (!cmp_vld_reg && !scan_issue) begin
                    state_next = ST_LOAD;
                end
            end

            ST_LOAD: begin
                // Hold until the output register is free, then hand over.
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_ok_next    = res_ok_reg;
                    m_rec_next   = res_rec_reg;
                    state_next   = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            front_reg   <= '0;
            m_valid_reg <= 1'b0;
            cmp_vld_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            front_reg   <= front_next;
            m_valid_reg <= m_valid_next;
            cmp_vld_reg <= cmp_vld_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        op_reg      <= op_next;
        in_rec_reg  <= in_rec_next;
        pos_reg     <= pos_next;
        idx_reg     <= idx_next;
        res_ok_reg  <= res_ok_next;
        res_rec_reg <= res_rec_next;
        m_ok_reg    <= m_ok_next;
        m_rec_reg   <= m_rec_next;
    end

    assign m_valid           = m_valid_reg;
    assign m_ok              = m_ok_reg;
    assign m_found_code      = m_rec_reg.code;
    assign m_found_name_low  = m_rec_reg.name_low;
    assign m_found_name_mid  = m_rec_reg.name_mid;
    assign m_found_name_high = m_rec_reg.name_high;
    assign m_found_age       = m_rec_reg.age;

endmodule

`default_nettype wire

// ----- hw/rtl/rdqs_checker.sv -----
// ----------------------------------------------------------------------------
// rdqs_checker: port-level checks of the record deque with search
// Watches the channels of the top level over time; bound to every instance.
// ----------------------------------------------------------------------------
`default_nettype none

module rdqs_checker (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_valid,
    input wire logic               s_ready,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire logic               m_ok,
    input wire logic signed [31:0] m_found_code,
    input wire logic [63:0]        m_found_name_low,
    input wire logic [63:0]        m_found_name_mid,
    input wire logic [31:0]        m_found_name_high,
    input wire logic [7:0]         m_found_age
);

    // Reset drops any pending result word.
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result word survived reset");

    // The sequencer takes one word at a time: busy right after accepting.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second word accepted while busy");

    // A failed result carries an all-zero record.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ok) |-> (m_found_code == 32'sd0 && m_found_name_low == 64'd0
            && m_found_name_mid == 64'd0 && m_found_name_high == 32'd0
            && m_found_age == 8'd0))
        else $error("failed result with nonzero record");

    // A stalled result word stays valid with its ok flag and code held.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_ok) && $stable(m_found_code)))
        else $error("stalled result word changed");

endmodule

bind record_deque_with_search_unit rdqs_checker u_rdqs_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .s_valid           (s_valid),
    .s_ready           (s_ready),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_ok              (m_ok),
    .m_found_code      (m_found_code),
    .m_found_name_low  (m_found_name_low),
    .m_found_name_mid  (m_found_name_mid),
    .m_found_name_high (m_found_name_high),
    .m_found_age       (m_found_age)
);

`default_nettype wire
